/* hdl/xbmc_pkg.sv */
`timescale 1ns / 1ps

package xbmc_pkg;

  localparam int unsigned KEY_MAX_DEF = 16;
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [4:0] BC_ENC_START = -5'sd6;
  localparam logic signed [4:0] BC_DEC_START = -5'sd8;
  localparam logic [7:0]        CHAR_PAD     = 8'h3D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_KEY_LEN  = 2'd1,
    CFG_KEY_LOW  = 2'd2,
    CFG_KEY_HIGH = 2'd3
  } cfg_reg_e;

  // One queued job: the full run of results caused by one input word.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] chars;
    logic [CNT_W-1:0]            cnt;
    logic                        has_data;
    logic                        msg_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(v) + 8'h41;
    end else if (v < 6'd52) begin
      r = 8'(v) + 8'h61 - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'(v) + 8'h30 - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Returns {valid, value}.
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

/* hdl/xor_base64_message_codec_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Word
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// input     in         in_valid_i / in_stall_o    op_i, data_byte_i, message_last_i
// result    out        out_valid_o / out_stall_i  out_byte_o, has_data_o, run_last_o,
//                                                 message_end_o
//
// An input word is taken and turned into a job of one to four results,
// queued two deep; results leave at one per cycle from the output stage while out_stall_i is low.
// Sustained rate is set by the result port.
// Reset clears configuration and codec state at once; no clearing pass.
// in_stall_o rises only while the job queue is full.

module xor_base64_message_codec_core import xbmc_pkg::*; #(
  parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  message_last_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  has_data_o,
  output logic                  run_last_o,
  output logic                  message_end_o
);

  logic      in_fire, push, pop;
  job_t      push_job, pop_job;
  q_status_t q_status;

  assign in_stall_o = q_status.full;
  assign in_fire    = in_valid_i && !q_status.full;

  xbmc_front #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_fire_i     (in_fire),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .message_last_i(message_last_i),
    .push_o        (push),
    .job_o         (push_job)
  );

  xbmc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .pop_job_o (pop_job),
    .status_o  (q_status)
  );

  xbmc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .q_job_i      (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .has_data_o   (has_data_o),
    .run_last_o   (run_last_o),
    .message_end_o(message_end_o)
  );

endmodule

/* hdl/xbmc_front.sv */
`timescale 1ns / 1ps

module xbmc_front import xbmc_pkg::*; #(
  parameter int unsigned KEY_MAX_BYTES = KEY_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  input  logic                  in_fire_i,
  input  logic                  op_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  message_last_i,
  output logic                  push_o,
  output job_t                  job_o
);

  localparam int unsigned KP_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] KEY_MAX_LEN = KEY_LEN_W'(KEY_MAX_BYTES);

  logic                              enable_q, enable_d;
  logic [KEY_LEN_W-1:0]              key_len_q, key_len_d;
  logic [KEY_MAX_BYTES-1:0][7:0]     key_q, key_d;
  logic [KP_W-1:0]                   kp_q, kp_d;
  logic [15:0]                       acc_q, acc_d;
  logic signed [4:0]                 bc_q, bc_d;
  logic [1:0]                        cm_q, cm_d;
  logic                              stop_q, stop_d;
  logic                              in_msg_q, in_msg_d;
  logic                              dir_q, dir_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    enable_d  = enable_q;
    key_len_d = key_len_q;
    key_d     = key_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ENABLE:  enable_d  = cfg_data_i[0];
        CFG_KEY_LEN: key_len_d = cfg_data_i[KEY_LEN_W-1:0];
        CFG_KEY_LOW: begin
          for (int i = 0; i < int'(KEY_MAX_BYTES); i++) begin
            if (i < 8) key_d[i] = cfg_data_i[8*(i%8) +: 8];
          end
        end
        CFG_KEY_HIGH: begin
          for (int i = 0; i < int'(KEY_MAX_BYTES); i++) begin
            if (i >= 8) key_d[i] = cfg_data_i[8*(i%8) +: 8];
          end
        end
      endcase
    end
  end

  always_comb begin
    logic                 start, dir, stop0, key_need, dec_emit, tail;
    logic [KP_W-1:0]      kp0, kp_use, kp_adv;
    logic [15:0]          acc0, acc_e, acc_dv, sh0, sh1, shd;
    logic signed [5:0]    bc0, bc1, bc2, bc3, bc_fin, bc_t, bc_d1, bc_d2;
    logic [1:0]           cm0, n_main, pad;
    logic [KEY_LEN_W-1:0] len, kp_next;
    logic [7:0]           kin, kout, c0, c1, ct, dbyte;
    logic [6:0]           dv;
    logic [2:0]           total;
    logic [23:0]          wide;

    kp_d     = kp_q;
    acc_d    = acc_q;
    bc_d     = bc_q;
    cm_d     = cm_q;
    stop_d   = stop_q;
    in_msg_d = in_msg_q;
    dir_d    = dir_q;
    push_o   = 1'b0;
    job_o    = '0;

    // A new message latches direction and restarts the codec state.
    start = !in_msg_q;
    dir   = start ? op_i : dir_q;
    kp0   = start ? '0 : kp_q;
    acc0  = start ? '0 : acc_q;
    bc0   = start ? (op_i ? {BC_DEC_START[4], BC_DEC_START}
                          : {BC_ENC_START[4], BC_ENC_START})
                  : {bc_q[4], bc_q};
    cm0   = start ? '0 : cm_q;
    stop0 = start ? 1'b0 : stop_q;

    // Decode path: six bits in, one byte out once eight are gathered.
    dv       = b64_value(data_byte_i);
    acc_dv   = {acc0[9:0], dv[5:0]};
    bc_d1    = bc0 + 6'sd6;
    bc_d2    = bc_d1 - 6'sd8;
    shd      = acc_dv >> bc_d1[3:0];
    dbyte    = shd[7:0];
    dec_emit = !stop0 && (data_byte_i != CHAR_PAD) && dv[6] && (bc_d1 >= 6'sd0);

    // Repeating key; a position past the current length wraps before use.
    len      = (key_len_q > KEY_MAX_LEN) ? KEY_MAX_LEN : key_len_q;
    kp_use   = (KEY_LEN_W'(kp0) >= len) ? '0 : kp0;
    kp_next  = KEY_LEN_W'(kp_use) + KEY_LEN_W'(1);
    kp_adv   = (kp_next >= len) ? '0 : KP_W'(kp_next);
    key_need = dir ? dec_emit : 1'b1;
    kin      = dir ? dbyte : data_byte_i;
    kout     = (len == '0) ? kin : (kin ^ key_q[kp_use]);

    // Encode path: eight bits in, one or two characters out, plus tail and padding at message end.
    acc_e = {acc0[7:0], kout};
    bc1   = bc0 + 6'sd8;
    bc2   = bc1 - 6'sd6;
    bc3   = bc2 - 6'sd6;
    sh0   = acc_e >> bc1[3:0];
    sh1   = acc_e >> bc2[3:0];
    c0    = b64_char(sh0[5:0]);
    c1    = b64_char(sh1[5:0]);
    if (bc1 < 6'sd0) begin
      n_main = 2'd0;
      bc_fin = bc1;
    end else if (bc2 < 6'sd0) begin
      n_main = 2'd1;
      bc_fin = bc2;
    end else begin
      n_main = 2'd2;
      bc_fin = bc3;
    end
    tail  = message_last_i && (bc_fin > -6'sd6);
    bc_t  = bc_fin + 6'sd8;
    wide  = {acc_e, 8'h00} >> bc_t[3:0];
    ct    = b64_char(wide[5:0]);
    pad   = message_last_i ? (2'd0 - cm0 - n_main - {1'b0, tail}) : 2'd0;
    total = 3'(n_main) + 3'(tail) + 3'(pad);
    if (total > 3'(MAX_RESULTS)) total = 3'(MAX_RESULTS);

    if (in_fire_i) begin
      if (!enable_q) begin
        job_o.chars[0] = data_byte_i;
        job_o.cnt      = CNT_W'(1);
        job_o.has_data = 1'b1;
        job_o.msg_end  = message_last_i;
        push_o         = 1'b1;
        if (message_last_i) in_msg_d = 1'b0;
      end else begin
        in_msg_d = 1'b1;
        dir_d    = dir;
        kp_d     = kp0;
        acc_d    = acc0;
        bc_d     = bc0[4:0];
        cm_d     = cm0;
        stop_d   = stop0;
        if (key_need && len != '0) kp_d = kp_adv;
        if (!dir) begin
          acc_d = acc_e;
          bc_d  = bc_fin[4:0];
          cm_d  = cm0 + n_main;
          for (int i = 0; i < int'(MAX_RESULTS); i++) begin
            if (i < int'(n_main)) begin
              job_o.chars[i] = (i == 0) ? c0 : c1;
            end else if (i == int'(n_main) && tail) begin
              job_o.chars[i] = ct;
            end else begin
              job_o.chars[i] = CHAR_PAD;
            end
          end
          job_o.cnt      = total;
          job_o.has_data = 1'b1;
          push_o         = (total != '0);
        end else if (!stop0) begin
          if (data_byte_i == CHAR_PAD) begin
            stop_d = 1'b1;
          end else if (dv[6]) begin
            acc_d = acc_dv;
            bc_d  = dec_emit ? bc_d2[4:0] : bc_d1[4:0];
            if (dec_emit) begin
              job_o.chars[0] = kout;
              job_o.cnt      = CNT_W'(1);
              job_o.has_data = 1'b1;
              push_o         = 1'b1;
            end
          end
        end
        if (message_last_i) begin
          // Nothing produced: send a bare end marker.
          if (!push_o) begin
            job_o          = '0;
            job_o.cnt      = CNT_W'(1);
            push_o         = 1'b1;
          end
          job_o.msg_end = 1'b1;
          in_msg_d      = 1'b0;
          kp_d          = '0;
          acc_d         = '0;
          cm_d          = '0;
          stop_d        = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      key_len_q <= '0;
      key_q     <= '0;
      kp_q      <= '0;
      acc_q     <= '0;
      bc_q      <= BC_ENC_START;
      cm_q      <= '0;
      stop_q    <= 1'b0;
      in_msg_q  <= 1'b0;
      dir_q     <= 1'b0;
    end else begin
      enable_q  <= enable_d;
      key_len_q <= key_len_d;
      key_q     <= key_d;
      kp_q      <= kp_d;
      acc_q     <= acc_d;
      bc_q      <= bc_d;
      cm_q      <= cm_d;
      stop_q    <= stop_d;
      in_msg_q  <= in_msg_d;
      dir_q     <= dir_d;
    end
  end

endmodule

/* hdl/xbmc_queue.sv */
`timescale 1ns / 1ps

module xbmc_queue import xbmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      push_job_i,
  input  logic      pop_i,
  output job_t      pop_job_o,
  output q_status_t status_o
);

  job_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_job_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

/* hdl/xbmc_back.sv */
`timescale 1ns / 1ps

module xbmc_back import xbmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_status_t q_status_i,
  input  job_t      q_job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] out_byte_o,
  output logic      has_data_o,
  output logic      run_last_o,
  output logic      message_end_o
);

  logic             busy_q, busy_d;
  job_t             job_q, job_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             take, at_end, free;

  assign take   = busy_q && !out_stall_i;
  assign at_end = (CNT_W'(idx_q) == job_q.cnt - CNT_W'(1));
  assign free   = !busy_q || (take && at_end);
  assign pop_o  = free && !q_status_i.empty;

  assign out_valid_o   = busy_q;
  assign out_byte_o    = job_q.chars[idx_q];
  assign has_data_o    = job_q.has_data;
  assign run_last_o    = at_end;
  assign message_end_o = at_end && job_q.msg_end;

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    idx_d  = idx_q;
    if (free) begin
      // load the next job, or go idle
      busy_d = !q_status_i.empty;
      job_d  = q_job_i;
      idx_d  = '0;
    end else if (take) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

/* hdl/xbmc_checker.sv */
`timescale 1ns / 1ps

module xbmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_data_o,
  input logic       run_last_o,
  input logic       message_end_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(message_end_o))
    else $error("stalled result changed");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> run_last_o)
    else $error("message end without run end");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> out_byte_o == 8'h00 && run_last_o && message_end_o)
    else $error("bad end marker");

  // a run that continues keeps the result valid next cycle
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("run broken before its last word");

endmodule

bind xor_base64_message_codec_core xbmc_checker u_chk (.*);

/* tb/tb_xor_base64_message_codec_core.sv */
`timescale 1ns / 1ps

module tb_xor_base64_message_codec_core import xbmc_pkg::*;;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_WORDS    = 12;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_data;
    logic       run_last;
    logic       msg_end;
  } codec_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic [7:0]            data_byte_i;
  logic                  message_last_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  has_data_o;
  logic                  run_last_o;
  logic                  message_end_o;

  xor_base64_message_codec_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .message_last_i(message_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_data_o    (has_data_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Codec copy: configuration and message state
  logic        cfg_enable   = 1'b0;
  logic [4:0]  cfg_key_len  = '0;
  logic [63:0] cfg_key_lo   = '0;
  logic [63:0] cfg_key_hi   = '0;
  logic [3:0]  st_key_pos   = '0;
  logic [15:0] st_acc       = '0;
  int          st_bits      = -6;
  logic [1:0]  st_quad      = '0;
  logic        st_stopped   = 1'b0;
  logic        st_in_msg    = 1'b0;
  logic        st_dir       = 1'b0;

  codec_result_t expected_results[$];

  bit calm = 1'b0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int b64_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_alpha[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic logic [7:0] key_xor(input logic [7:0] b);
    int len;
    int kp;
    logic [7:0] k;
    len = (cfg_key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(cfg_key_len);
    if (len == 0) return b;
    if (st_key_pos >= len) st_key_pos = '0;
    kp = st_key_pos;
    k = (kp < 8) ? cfg_key_lo[8*kp +: 8] : cfg_key_hi[8*(kp-8) +: 8];
    st_key_pos = (kp + 1 >= len) ? 4'd0 : 4'(kp + 1);
    return b ^ k;
  endfunction

  function automatic codec_result_t emit_char(input logic [7:0] c);
    st_quad = st_quad + 2'd1;
    return '{c, 1'b1, 1'b0, 1'b0};
  endfunction

  task automatic predict_codec_word(input logic op, input logic [7:0] b, input logic last);
    codec_result_t run [6];
    int n;
    int v;
    logic [7:0] x;
    logic [23:0] wide;
    n = 0;
    if (!cfg_enable) begin
      run[0] = '{b, 1'b1, 1'b0, last};
      n = 1;
      if (last) st_in_msg = 1'b0;
    end else begin
      if (!st_in_msg) begin
        st_in_msg  = 1'b1;
        st_dir     = op;
        st_key_pos = '0;
        st_acc     = '0;
        st_bits    = op ? -8 : -6;
        st_quad    = '0;
        st_stopped = 1'b0;
      end
      if (!st_dir) begin
        x = key_xor(b);
        st_acc = {st_acc[7:0], x};
        st_bits += 8;
        while (st_bits >= 0) begin
          run[n] = emit_char(b64_alpha[6'(st_acc >> st_bits)]);
          n++;
          st_bits -= 6;
        end
        if (last) begin
          // flush the partial group, then pad to a multiple of four characters
          if (st_bits > -6) begin
            wide = {st_acc, 8'h00};
            run[n] = emit_char(b64_alpha[6'(wide >> (st_bits + 8))]);
            n++;
          end
          while (st_quad != 2'd0) begin
            run[n] = emit_char(CHAR_PAD);
            n++;
          end
        end
      end else if (!st_stopped) begin
        if (b == CHAR_PAD) begin
          st_stopped = 1'b1;
        end else begin
          v = b64_index(b);
          if (v >= 0) begin
            st_acc = {st_acc[9:0], 6'(v)};
            st_bits += 6;
            if (st_bits >= 0) begin
              run[n] = '{key_xor(8'(st_acc >> st_bits)), 1'b1, 1'b0, 1'b0};
              n++;
              st_bits -= 8;
            end
          end
        end
      end
      if (last) begin
        if (n == 0) begin
          run[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
          n = 1;
        end
        run[n-1].msg_end = 1'b1;
        st_in_msg  = 1'b0;
        st_key_pos = '0;
        st_acc     = '0;
        st_quad    = '0;
        st_stopped = 1'b0;
      end
    end
    if (n > 0) run[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_results = {expected_results, run[i]};
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 6) gap = $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i = op;
    data_byte_i = b;
    message_last_i = last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    predict_codec_word(op, b, last);
    words_sent++;
  endtask

  task automatic send_text(input logic op, input string s);
    for (int i = 0; i < s.len(); i++) send_word(op, s[i], i == s.len() - 1);
  endtask

  // Drop the input, drain every result, then allow the block to go quiet.
  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ENABLE:   cfg_enable  = val[0];
      CFG_KEY_LEN:  cfg_key_len = val[4:0];
      CFG_KEY_LOW:  cfg_key_lo  = val;
      CFG_KEY_HIGH: cfg_key_hi  = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input logic [63:0] en_word, input logic [63:0] len_word,
                           input logic [63:0] lo, input logic [63:0] hi);
    settle();
    write_reg(CFG_ENABLE, en_word);
    write_reg(CFG_KEY_LEN, len_word);
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
  endtask

  task automatic test_passthrough();
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b1, 8'hFF, 1'b1);
    send_word(1'b0, 8'h41, 1'b1);
  endtask

  task automatic test_encode_padding();
    configure(64'd1, 64'd0, '0, '0);
    send_text(1'b0, "M");
    send_text(1'b0, "Ma");
    send_text(1'b0, "Man");
  endtask

  task automatic test_key_saturation();
    // length above the key size acts as the full key
    configure(64'd1, 64'd31, '1, '0);
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b0, 8'hFF, 1'b0);
    send_word(1'b0, 8'h00, 1'b0);
    send_word(1'b0, 8'hFF, 1'b1);
  endtask

  task automatic test_key_change_mid_message();
    configure(64'd1, 64'd8, {$urandom, $urandom}, {$urandom, $urandom});
    for (int i = 0; i < 5; i++) send_word(1'b0, 8'($urandom_range(255)), 1'b0);
    // shrink the key below the current position; it must wrap
    settle();
    write_reg(CFG_KEY_LEN, 64'd3);
    send_word(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_decode_cases();
    configure(64'd1, 64'd0, '0, '0);
    send_text(1'b1, "TW=X");
    send_text(1'b1, "*");
  endtask

  task automatic send_random_message(inout int count);
    logic [7:0] bytes[$];
    logic op;
    int len;
    int nchar;
    logic [7:0] junk;
    op = 1'($urandom_range(1));
    if (op == 1'b0) begin
      len = ($urandom_range(99) < 20) ? $urandom_range(18, 9) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom_range(255))};
    end else if ($urandom_range(99) < 75) begin
      nchar = $urandom_range(9, 2);
      if (nchar % 4 == 1) nchar++;
      for (int i = 0; i < nchar; i++) begin
        if ($urandom_range(99) < 10) begin
          do junk = 8'($urandom_range(255));
          while (b64_index(junk) >= 0 || junk == CHAR_PAD);
          bytes = {bytes, junk};
        end
        bytes = {bytes, 8'(b64_alpha[$urandom_range(63)])};
      end
      while (nchar % 4 != 0) begin
        bytes = {bytes, CHAR_PAD};
        nchar++;
      end
      if ($urandom_range(99) < 15) bytes = {bytes, 8'(b64_alpha[$urandom_range(63)])};
    end else begin
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom_range(255))};
    end
    foreach (bytes[i]) send_word(op, bytes[i], i == bytes.size() - 1);
    count += bytes.size();
  endtask

  task automatic test_random_traffic();
    logic [63:0] junk;
    logic [63:0] lo;
    logic [63:0] hi;
    logic en;
    logic [4:0] klen;
    int count;
    for (int phase = 0; phase < 6; phase++) begin
      junk = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      en = 1'b1;
      case (phase)
        0: klen = 5'd5;
        1: klen = 5'd16;
        2: begin
          en = 1'b0;
          klen = 5'($urandom_range(31));
        end
        3: klen = 5'd0;
        4: begin
          klen = 5'($urandom_range(31));
          lo = '0;
          hi = '0;
        end
        default: begin
          klen = 5'd1;
          lo = '1;
          hi = '1;
        end
      endcase
      configure({junk[63:1], en}, {junk[63:5], klen}, lo, hi);
      calm = (phase == 0);
      count = 0;
      while (count < PHASE_WORDS) send_random_message(count);
    end
    calm = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 11);
  end

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    codec_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got byte %h has %b", $time,
                 out_byte_o, has_data_o);
      end else begin
        want = expected_results.pop_front();
        compare_field("out_byte", want.ch, out_byte_o);
        compare_field("has_data", 8'(want.has_data), 8'(has_data_o));
        compare_field("run_last", 8'(want.run_last), 8'(run_last_o));
        compare_field("message_end", 8'(want.msg_end), 8'(message_end_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 WATCHDOG_LIMIT, expected_results.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ENABLE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = 1'b0;
    data_byte_i = '0;
    message_last_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_passthrough();
    test_encode_padding();
    test_key_saturation();
    test_key_change_mid_message();
    test_decode_cases();
    test_random_traffic();

    settle();
    repeat (16) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results, %0d register writes.", words_sent,
             results_seen, cfg_writes);
    $display("Covered passthrough, encode padding, decode skip and stop, key wrap and clamp.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
